FILE: rtl/assert_macros.svh
// assertion macros shared by the alu rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alu assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alu assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/lralu_pkg.sv
// types, opcodes and flag positions for the 8-bit alu
`timescale 1ns / 1ps
package lralu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_SWAP  = 5'd10,
    OP_DAA   = 5'd11,
    OP_CPL   = 5'd12,
    OP_CCF   = 5'd13,
    OP_SCF   = 5'd14,
    OP_RLC   = 5'd15,
    OP_RL    = 5'd16,
    OP_RRC   = 5'd17,
    OP_RR    = 5'd18,
    OP_SLA   = 5'd19,
    OP_SRA   = 5'd20,
    OP_SRL   = 5'd21,
    OP_BIT   = 5'd22,
    OP_SET   = 5'd23,
    OP_RES   = 5'd24,
    OP_ADD16 = 5'd25,
    OP_ADDSP = 5'd26,
    OP_RLCA  = 5'd27,
    OP_RLA   = 5'd28,
    OP_RRCA  = 5'd29,
    OP_RRA   = 5'd30
  } alu_op_t;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_LIM = 8'h99;
  localparam logic [3:0] DAA_LO_LIM = 4'h9;

  typedef struct packed {
    logic [4:0]  cmd;
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic [7:0]  operand8;
    logic [2:0]  bit_index;
    logic [15:0] pair;
    logic [15:0] operand16;
  } alu_req_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  value;
    logic [15:0] pair;
    logic [3:0]  flags;
  } alu_res_t;

endpackage

FILE: rtl/lralu_in_if.sv
// request channel of the alu
`timescale 1ns / 1ps
interface lralu_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [7:0]  acc_in;
  logic [3:0]  flags_in;
  logic [7:0]  operand8;
  logic [2:0]  bit_index;
  logic [15:0] pair_in;
  logic [15:0] operand16;

  modport source (
    output valid, cmd, acc_in, flags_in, operand8, bit_index, pair_in, operand16,
    input  ready
  );
  modport sink (
    input  valid, cmd, acc_in, flags_in, operand8, bit_index, pair_in, operand16,
    output ready
  );
endinterface

FILE: rtl/lralu_out_if.sv
// result channel of the alu
`timescale 1ns / 1ps
interface lralu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  acc_out;
  logic [7:0]  value_out;
  logic [15:0] pair_out;
  logic [3:0]  flags_out;

  modport source (
    output valid, acc_out, value_out, pair_out, flags_out,
    input  ready
  );
  modport sink (
    input  valid, acc_out, value_out, pair_out, flags_out,
    output ready
  );
endinterface

FILE: rtl/lralu_in_stage.sv
// input register stage of the alu
`timescale 1ns / 1ps
module lralu_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  lralu_in_if.sink            in_ch,
  output logic                req_valid,
  output lralu_pkg::alu_req_t req,
  input  logic                req_ready
);
  import lralu_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  alu_req_t req_r;
  logic     take;

  assign in_ch.ready = !valid_r || req_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (req_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= '{cmd:       in_ch.cmd,
                 acc:       in_ch.acc_in,
                 flags:     in_ch.flags_in,
                 operand8:  in_ch.operand8,
                 bit_index: in_ch.bit_index,
                 pair:      in_ch.pair_in,
                 operand16: in_ch.operand16};
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;
endmodule

FILE: rtl/lralu_core.sv
// combinational alu datapath and flag logic
`timescale 1ns / 1ps
module lralu_core (
  input  lralu_pkg::alu_req_t req,
  output lralu_pkg::alu_res_t res
);
  import lralu_pkg::*;

  alu_op_t     op;
  logic [7:0]  a;
  logic [7:0]  v;
  logic        zf, nf, hf, cf;
  logic        cin;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [7:0]  daa_v;
  logic        daa_c;
  logic        acc_rot;
  logic [7:0]  rx;
  logic [7:0]  rot_v;
  logic        rot_c;
  logic [7:0]  bit_mask;
  logic [16:0] add16_sum;
  logic [12:0] add16_lo;
  logic [15:0] sp_sum;
  logic [4:0]  sp_lo;
  logic [8:0]  sp_byte;

  assign op  = alu_op_t'(req.cmd);
  assign a   = req.acc;
  assign v   = req.operand8;
  assign zf  = req.flags[FLAG_Z];
  assign nf  = req.flags[FLAG_N];
  assign hf  = req.flags[FLAG_H];
  assign cf  = req.flags[FLAG_C];
  assign cin = (op == OP_ADC || op == OP_SBC) ? cf : 1'b0;

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, cin};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

  always_comb begin
    daa_v = a;
    daa_c = cf;
    if (!nf) begin
      if (cf || (a > DAA_HI_LIM)) begin
        daa_v = daa_v + DAA_HI_ADJ;
        daa_c = 1'b1;
      end
      if (hf || (a[3:0] > DAA_LO_LIM)) begin
        daa_v = daa_v + DAA_LO_ADJ;
      end
    end else begin
      if (cf) begin
        daa_v = daa_v - DAA_HI_ADJ;
      end
      if (hf) begin
        daa_v = daa_v - DAA_LO_ADJ;
      end
    end
  end

  // accumulator rotates share the cb rotate logic
  assign acc_rot = (op == OP_RLCA) || (op == OP_RLA) || (op == OP_RRCA) || (op == OP_RRA);
  assign rx      = acc_rot ? a : v;

  always_comb begin
    rot_v = rx;
    rot_c = cf;
    case (op)
      OP_RLC, OP_RLCA: begin
        rot_v = {rx[6:0], rx[7]};
        rot_c = rx[7];
      end
      OP_RL, OP_RLA: begin
        rot_v = {rx[6:0], cf};
        rot_c = rx[7];
      end
      OP_RRC, OP_RRCA: begin
        rot_v = {rx[0], rx[7:1]};
        rot_c = rx[0];
      end
      OP_RR, OP_RRA: begin
        rot_v = {cf, rx[7:1]};
        rot_c = rx[0];
      end
      OP_SLA: begin
        rot_v = {rx[6:0], 1'b0};
        rot_c = rx[7];
      end
      OP_SRA: begin
        rot_v = {rx[7], rx[7:1]};
        rot_c = rx[0];
      end
      OP_SRL: begin
        rot_v = {1'b0, rx[7:1]};
        rot_c = rx[0];
      end
      default: begin
        rot_v = rx;
        rot_c = cf;
      end
    endcase
  end

  assign bit_mask  = 8'd1 << req.bit_index;
  assign add16_sum = {1'b0, req.pair} + {1'b0, req.operand16};
  assign add16_lo  = {1'b0, req.pair[11:0]} + {1'b0, req.operand16[11:0]};
  assign sp_sum    = req.pair + {{8{v[7]}}, v};
  assign sp_lo     = {1'b0, req.pair[3:0]} + {1'b0, v[3:0]};
  assign sp_byte   = {1'b0, req.pair[7:0]} + {1'b0, v};

  always_comb begin
    res.acc   = a;
    res.value = v;
    res.pair  = req.pair;
    res.flags = req.flags;
    case (op)
      OP_ADD, OP_ADC: begin
        res.acc   = sum9[7:0];
        res.flags = {(sum9[7:0] == 8'd0), 1'b0, sum_lo[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        res.acc   = dif9[7:0];
        res.flags = {(dif9[7:0] == 8'd0), 1'b1, dif_lo[4], dif9[8]};
      end
      OP_CP: begin
        res.flags = {(dif9[7:0] == 8'd0), 1'b1, dif_lo[4], dif9[8]};
      end
      OP_AND: begin
        res.acc   = a & v;
        res.flags = {((a & v) == 8'd0), 1'b0, 1'b1, 1'b0};
      end
      OP_OR: begin
        res.acc   = a | v;
        res.flags = {((a | v) == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_XOR: begin
        res.acc   = a ^ v;
        res.flags = {((a ^ v) == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_INC: begin
        res.value = v + 8'd1;
        res.flags = {(v == 8'hff), 1'b0, (v[3:0] == 4'hf), cf};
      end
      OP_DEC: begin
        res.value = v - 8'd1;
        res.flags = {(v == 8'h01), 1'b1, (v[3:0] == 4'h0), cf};
      end
      OP_SWAP: begin
        res.value = {v[3:0], v[7:4]};
        res.flags = {(v == 8'd0), 1'b0, 1'b0, 1'b0};
      end
      OP_DAA: begin
        res.acc   = daa_v;
        res.flags = {(daa_v == 8'd0), nf, 1'b0, daa_c};
      end
      OP_CPL: begin
        res.acc   = ~a;
        res.flags = {zf, 1'b1, 1'b1, cf};
      end
      OP_CCF: begin
        res.flags = {zf, 1'b0, 1'b0, !cf};
      end
      OP_SCF: begin
        res.flags = {zf, 1'b0, 1'b0, 1'b1};
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR, OP_SLA, OP_SRA, OP_SRL: begin
        res.value = rot_v;
        res.flags = {(rot_v == 8'd0), 1'b0, 1'b0, rot_c};
      end
      OP_RLCA, OP_RLA, OP_RRCA, OP_RRA: begin
        res.acc   = rot_v;
        res.flags = {1'b0, 1'b0, 1'b0, rot_c};
      end
      OP_BIT: begin
        res.flags = {((v & bit_mask) == 8'd0), 1'b0, 1'b1, cf};
      end
      OP_SET: begin
        res.value = v | bit_mask;
      end
      OP_RES: begin
        res.value = v & ~bit_mask;
      end
      OP_ADD16: begin
        res.pair  = add16_sum[15:0];
        res.flags = {zf, 1'b0, add16_lo[12], add16_sum[16]};
      end
      OP_ADDSP: begin
        res.pair  = sp_sum;
        res.flags = {1'b0, 1'b0, sp_lo[4], sp_byte[8]};
      end
      default: begin
        res.acc   = a;
        res.value = v;
        res.pair  = req.pair;
        res.flags = req.flags;
      end
    endcase
  end
endmodule

FILE: rtl/lralu_out_stage.sv
// result register stage of the alu
`timescale 1ns / 1ps
module lralu_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  lralu_pkg::alu_res_t res,
  output logic                res_ready,
  lralu_out_if.source         out_ch
);
  import lralu_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  alu_res_t res_r;
  logic     take;

  assign res_ready = !valid_r || out_ch.ready;
  assign take      = res_valid && res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.acc_out   = res_r.acc;
  assign out_ch.value_out = res_r.value;
  assign out_ch.pair_out  = res_r.pair;
  assign out_ch.flags_out = res_r.flags;
endmodule

FILE: rtl/eight_bit_cpu_alu_with_flags.sv
// top level of the 8-bit cpu alu with flags
// an accepted transaction is held in the input register, then in the output register, where its result is valid
// throughput: one transaction per cycle while out_ch.ready is high, set by the single alu pass between registers
// an empty input register takes a new transaction while a finished result waits at the output register
// reset: synchronous active-low rst_n empties both register stages
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eight_bit_cpu_alu_with_flags (
  input logic          clk,
  input logic          rst_n,
  lralu_in_if.sink     in_ch,
  lralu_out_if.source  out_ch
);
  import lralu_pkg::*;

  logic     req_valid;
  logic     req_ready;
  alu_req_t req;
  alu_res_t res;

  lralu_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  lralu_core u_core (
    .req (req),
    .res (res)
  );

  lralu_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (req_valid),
    .res       (res),
    .res_ready (req_ready),
    .out_ch    (out_ch)
  );

  `ASSERT_NEXT(a_accept_fills, clk, rst_n, in_ch.valid && in_ch.ready, req_valid)
  `ASSERT_NEXT(a_stage_moves, clk, rst_n, req_valid && req_ready, out_ch.valid)
  `ASSERT_NEXT(a_stall_holds, clk, rst_n, req_valid && !req_ready, req_valid && $stable(req))
  `ASSERT_NEXT(a_cp_keeps_acc, clk, rst_n, req_valid && req_ready && (req.cmd == OP_CP), out_ch.acc_out == $past(req.acc))
  `ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !req_valid, in_ch.ready)
endmodule
